@@ rtl/core/rwsd_pkg.sv @@
// Shared constants, types and codes of the rolling window standard deviation block.
`timescale 1ns / 1ps
`default_nettype none
package rwsd_pkg;

    // Sizing of the window store and the sample format
    localparam int MAX_WINDOW   = 64;
    localparam int SAMPLE_BITS  = 24;
    localparam int STD_BITS     = 24;
    localparam int RESET_WINDOW = 3;

    // Configuration port
    localparam int CFG_LEN_W  = 7;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_MODE   = 1'd1;

    // Stream widths, padded to whole bytes
    localparam int S_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((STD_BITS + 7) / 8) * 8;

    // Derived datapath widths
    localparam int RING_AW   = $clog2(MAX_WINDOW);
    localparam int WIN_W     = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W     = SAMPLE_BITS + RING_AW + 1;
    localparam int SQ_W      = 2 * SAMPLE_BITS + RING_AW;
    localparam int NUM_W     = SQ_W + WIN_W;
    localparam int MUL_W     = SUM_W;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int DEN_W     = 2 * WIN_W;
    localparam int QUOT_BITS = 2 * STD_BITS;
    localparam int SQ_RW     = STD_BITS + 3;
    localparam int CNT_W     = $clog2(QUOT_BITS + WIN_W + 1);

    localparam logic [STD_BITS-1:0] STD_MAX = '1;

    // Shared unit operation codes
    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    typedef struct packed {
        logic [NUM_W-1:0] a;
        logic [NUM_W-1:0] b;
        logic             op;
        logic             mul_en;
        logic [MUL_W-1:0] ma;
        logic [MUL_W-1:0] mb;
    } alu_req_t;

    typedef struct packed {
        logic [NUM_W-1:0]  res;
        logic              ge;
        logic [PROD_W-1:0] prod;
    } alu_rsp_t;

endpackage
`default_nettype wire

@@ rtl/core/rwsd_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module rwsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]              rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

@@ rtl/core/rwsd_alu.sv @@
// Shared arithmetic unit: one add/subtract-compare and one registered multiplier.
`timescale 1ns / 1ps
`default_nettype none
module rwsd_alu (
    input  wire logic              aclk,
    input  wire rwsd_pkg::alu_req_t req,
    output rwsd_pkg::alu_rsp_t     rsp
);

    logic [rwsd_pkg::NUM_W-1:0]  b_sel;
    logic [rwsd_pkg::NUM_W:0]    sum_ext;
    logic [rwsd_pkg::PROD_W-1:0] prod_reg;

    // subtract as a + ~b + 1; carry out is the unsigned a >= b flag
    always_comb begin
        b_sel   = (req.op == rwsd_pkg::ALU_SUB) ? ~req.b : req.b;
        sum_ext = {1'b0, req.a} + {1'b0, b_sel}
                + (rwsd_pkg::NUM_W + 1)'(req.op == rwsd_pkg::ALU_SUB);
    end

    always_ff @(posedge aclk) begin
        if (req.mul_en) begin
            prod_reg <= rwsd_pkg::PROD_W'(req.ma) * rwsd_pkg::PROD_W'(req.mb);
        end
    end

    always_comb begin
        rsp.res  = sum_ext[rwsd_pkg::NUM_W-1:0];
        rsp.ge   = sum_ext[rwsd_pkg::NUM_W];
        rsp.prod = prod_reg;
    end

endmodule
`default_nettype wire

@@ rtl/core/rolling_window_std_dev.sv @@
// Top level: sliding-window standard deviation with a sequencer over one shared unit.
// A transaction is accepted only in idle; the next one waits until its result is handed
//   to the output register. Saturation and divide by zero skip divide and root.
// An item that leaves the window short, or window zero, returns to idle with no result.
// The 48-step restoring divide and 24-step root both run on the shared adder.
// Reset (aresetn low, synchronous): window 3, sample mode, empty window; ring not cleared.
`timescale 1ns / 1ps
`default_nettype none
module rolling_window_std_dev (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration writes
    input  wire logic                               cfg_wr_en,
    input  wire logic [rwsd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rwsd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // sample stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [rwsd_pkg::S_TDATA_W-1:0]     s_tdata,   // [23:0] return_value
    input  wire logic                               s_tuser,   // [0] series_start
    // result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [rwsd_pkg::M_TDATA_W-1:0]          m_tdata,   // [23:0] std_dev
    output logic                                    m_tuser    // [0] div_error
);

    // sequencer codes
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_READ = 4'd1;   // fetch leaving sample, square x
    localparam logic [3:0] S_ADDX = 4'd2;   // add x^2, update sum, square y
    localparam logic [3:0] S_SUBY = 4'd3;   // drop y^2, store x, fill check
    localparam logic [3:0] S_PREP = 4'd4;   // set up n*sumSq, start n*d
    localparam logic [3:0] S_NMUL = 4'd5;   // shift-add n*sumSq
    localparam logic [3:0] S_NUM  = 4'd6;   // subtract sum^2
    localparam logic [3:0] S_CHK  = 4'd7;   // saturation check
    localparam logic [3:0] S_DIV  = 4'd8;   // restoring divide, one bit per cycle
    localparam logic [3:0] S_SQRT = 4'd9;   // restoring root, one bit per cycle
    localparam logic [3:0] S_EMIT = 4'd10;  // hand off to output register

    localparam int AW  = rwsd_pkg::RING_AW;
    localparam int WW  = rwsd_pkg::WIN_W;
    localparam int QB  = rwsd_pkg::QUOT_BITS;
    localparam int SB  = rwsd_pkg::STD_BITS;
    localparam int NW  = rwsd_pkg::NUM_W;

    function automatic logic [rwsd_pkg::MUL_W-1:0] mag_of(
        input logic signed [rwsd_pkg::SUM_W-1:0] v
    );
        mag_of = v[rwsd_pkg::SUM_W-1] ? rwsd_pkg::MUL_W'(-v) : rwsd_pkg::MUL_W'(v);
    endfunction

    // ---------------- registers ----------------
    logic [3:0]                        state_reg, state_next;
    logic [rwsd_pkg::CFG_LEN_W-1:0]    win_len_reg, win_len_next;
    logic                              mode_reg, mode_next;
    logic [AW-1:0]                     slot_reg, slot_next;
    logic [WW-1:0]                     fill_reg, fill_next;
    logic signed [rwsd_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [rwsd_pkg::SQ_W-1:0]         sq_reg, sq_next;

    logic signed [rwsd_pkg::SAMPLE_BITS-1:0] x_reg, x_next;
    logic [WW-1:0]                     n_reg, n_next;
    logic                              have_old_reg, have_old_next;
    logic [NW-1:0]                     acc_reg, acc_next;
    logic [NW-1:0]                     mcand_reg, mcand_next;
    logic [WW-1:0]                     mplier_reg, mplier_next;
    logic [rwsd_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [rwsd_pkg::DEN_W-1:0]        den_reg, den_next;
    logic [rwsd_pkg::DEN_W-1:0]        drem_reg, drem_next;
    logic [QB-1:0]                     quo_reg, quo_next;
    logic [rwsd_pkg::SQ_RW-1:0]        srem_reg, srem_next;
    logic [SB-1:0]                     root_reg, root_next;
    logic                              err_reg, err_next;

    logic                              m_valid_reg, m_valid_next;
    logic [SB-1:0]                     m_std_reg, m_std_next;
    logic                              m_err_reg, m_err_next;

    // ---------------- shared unit and ring ----------------
    rwsd_pkg::alu_req_t alu_req;
    rwsd_pkg::alu_rsp_t alu_rsp;

    rwsd_alu u_alu (
        .aclk (aclk),
        .req  (alu_req),
        .rsp  (alu_rsp)
    );

    logic                             ram_we;
    logic                             ram_re;
    logic [AW-1:0]                    ram_raddr;
    logic [rwsd_pkg::SAMPLE_BITS-1:0] ram_rdata;

    rwsd_ram #(
        .WIDTH (rwsd_pkg::SAMPLE_BITS),
        .DEPTH (rwsd_pkg::MAX_WINDOW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (slot_reg),
        .wr_data (x_reg),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // ---------------- helpers ----------------
    logic signed [rwsd_pkg::SUM_W-1:0] x_ext, y_ext;
    logic [AW+1:0]                     old_sum;
    logic [WW-1:0]                     d_val;
    logic [WW-1:0]                     fill_inc;
    logic [WW-1:0]                     n_clamp;
    logic                              full;
    logic [rwsd_pkg::DEN_W:0]          div_trial;
    logic [rwsd_pkg::SQ_RW-1:0]        sq_rp;
    logic                              series_clear;

    always_comb begin
        x_ext = rwsd_pkg::SUM_W'(x_reg);
        y_ext = rwsd_pkg::SUM_W'($signed(ram_rdata));
        // slot of the sample leaving the window, (slot - n) mod MAX_WINDOW
        old_sum = (AW + 2)'(slot_reg) + (AW + 2)'(rwsd_pkg::MAX_WINDOW) - (AW + 2)'(n_reg);
        if (old_sum >= (AW + 2)'(rwsd_pkg::MAX_WINDOW)) begin
            old_sum = old_sum - (AW + 2)'(rwsd_pkg::MAX_WINDOW);
        end
        d_val    = mode_reg ? (n_reg - WW'(1)) : n_reg;
        fill_inc = fill_reg + WW'(1);
        full     = have_old_reg || (fill_inc == n_reg);
        if (int'(win_len_reg) > rwsd_pkg::MAX_WINDOW) begin
            n_clamp = WW'(rwsd_pkg::MAX_WINDOW);
        end else begin
            n_clamp = WW'(win_len_reg);
        end
        div_trial = {drem_reg, quo_reg[QB-1]};
        sq_rp     = {srem_reg[rwsd_pkg::SQ_RW-3:0], quo_reg[QB-1 -: 2]};
    end

    // ---------------- sequencer ----------------
    always_comb begin
        state_next    = state_reg;
        win_len_next  = win_len_reg;
        mode_next     = mode_reg;
        slot_next     = slot_reg;
        fill_next     = fill_reg;
        sum_next      = sum_reg;
        sq_next       = sq_reg;
        x_next        = x_reg;
        n_next        = n_reg;
        have_old_next = have_old_reg;
        acc_next      = acc_reg;
        mcand_next    = mcand_reg;
        mplier_next   = mplier_reg;
        cnt_next      = cnt_reg;
        den_next      = den_reg;
        drem_next     = drem_reg;
        quo_next      = quo_reg;
        srem_next     = srem_reg;
        root_next     = root_reg;
        err_next      = err_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_std_next    = m_std_reg;
        m_err_next    = m_err_reg;

        alu_req       = '0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_raddr     = AW'(old_sum);
        series_clear  = 1'b0;

        // configuration; a new window length restarts the series
        if (cfg_wr_en) begin
            case (cfg_index)
                rwsd_pkg::CFG_WINDOW_LENGTH: begin
                    win_len_next = cfg_wdata[rwsd_pkg::CFG_LEN_W-1:0];
                    series_clear = 1'b1;
                end
                rwsd_pkg::CFG_SAMPLE_MODE: begin
                    mode_next = cfg_wdata[0];
                end
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    x_next     = s_tdata[rwsd_pkg::SAMPLE_BITS-1:0];
                    n_next     = n_clamp;
                    state_next = S_READ;
                    if (s_tuser) begin
                        series_clear = 1'b1;
                    end
                end
            end
            S_READ: begin
                if (n_reg == '0) begin
                    state_next = S_IDLE;
                end else begin
                    ram_re         = 1'b1;
                    have_old_next  = (fill_reg >= n_reg);
                    alu_req.mul_en = 1'b1;
                    alu_req.ma     = mag_of(x_ext);
                    alu_req.mb     = mag_of(x_ext);
                    state_next     = S_ADDX;
                end
            end
            S_ADDX: begin
                alu_req.a  = NW'(sq_reg);
                alu_req.b  = NW'(alu_rsp.prod);
                alu_req.op = rwsd_pkg::ALU_ADD;
                sq_next    = rwsd_pkg::SQ_W'(alu_rsp.res);
                sum_next   = sum_reg + x_ext - (have_old_reg ? y_ext : '0);
                alu_req.mul_en = have_old_reg;
                alu_req.ma     = mag_of(y_ext);
                alu_req.mb     = mag_of(y_ext);
                state_next     = S_SUBY;
            end
            S_SUBY: begin
                if (have_old_reg) begin
                    alu_req.a  = NW'(sq_reg);
                    alu_req.b  = NW'(alu_rsp.prod);
                    alu_req.op = rwsd_pkg::ALU_SUB;
                    sq_next    = rwsd_pkg::SQ_W'(alu_rsp.res);
                end else begin
                    fill_next = fill_inc;
                end
                ram_we = 1'b1;
                if (slot_reg == AW'(rwsd_pkg::MAX_WINDOW - 1)) begin
                    slot_next = '0;
                end else begin
                    slot_next = slot_reg + AW'(1);
                end
                if (!full) begin
                    state_next = S_IDLE;
                end else if (d_val == '0) begin
                    root_next  = '0;
                    err_next   = 1'b1;
                    state_next = S_EMIT;
                end else begin
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                mcand_next     = NW'(sq_reg);
                mplier_next    = n_reg;
                acc_next       = '0;
                cnt_next       = rwsd_pkg::CNT_W'(WW);
                alu_req.mul_en = 1'b1;
                alu_req.ma     = rwsd_pkg::MUL_W'(n_reg);
                alu_req.mb     = rwsd_pkg::MUL_W'(d_val);
                state_next     = S_NMUL;
            end
            S_NMUL: begin
                alu_req.a  = acc_reg;
                alu_req.b  = mcand_reg;
                alu_req.op = rwsd_pkg::ALU_ADD;
                if (mplier_reg[0]) begin
                    acc_next = alu_rsp.res;
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg - rwsd_pkg::CNT_W'(1);
                // first pass: n*d has landed; start sum^2 in its place
                if (cnt_reg == rwsd_pkg::CNT_W'(WW)) begin
                    den_next       = alu_rsp.prod[rwsd_pkg::DEN_W-1:0];
                    alu_req.mul_en = 1'b1;
                    alu_req.ma     = mag_of(sum_reg);
                    alu_req.mb     = mag_of(sum_reg);
                end
                if (cnt_reg == rwsd_pkg::CNT_W'(1)) begin
                    state_next = S_NUM;
                end
            end
            S_NUM: begin
                alu_req.a  = acc_reg;
                alu_req.b  = alu_rsp.prod[NW-1:0];
                alu_req.op = rwsd_pkg::ALU_SUB;
                acc_next   = alu_rsp.res;
                state_next = S_CHK;
            end
            S_CHK: begin
                // quotient of 2^48 or more means the root overflows 24 bits
                alu_req.a  = acc_reg >> QB;
                alu_req.b  = NW'(den_reg);
                alu_req.op = rwsd_pkg::ALU_SUB;
                if (alu_rsp.ge) begin
                    root_next  = rwsd_pkg::STD_MAX;
                    err_next   = 1'b0;
                    state_next = S_EMIT;
                end else begin
                    drem_next  = rwsd_pkg::DEN_W'(acc_reg >> QB);
                    quo_next   = acc_reg[QB-1:0];
                    cnt_next   = rwsd_pkg::CNT_W'(QB);
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                alu_req.a  = NW'(div_trial);
                alu_req.b  = NW'(den_reg);
                alu_req.op = rwsd_pkg::ALU_SUB;
                if (alu_rsp.ge) begin
                    drem_next = rwsd_pkg::DEN_W'(alu_rsp.res);
                end else begin
                    drem_next = div_trial[rwsd_pkg::DEN_W-1:0];
                end
                quo_next = {quo_reg[QB-2:0], alu_rsp.ge};
                cnt_next = cnt_reg - rwsd_pkg::CNT_W'(1);
                if (cnt_reg == rwsd_pkg::CNT_W'(1)) begin
                    srem_next  = '0;
                    root_next  = '0;
                    cnt_next   = rwsd_pkg::CNT_W'(SB);
                    state_next = S_SQRT;
                end
            end
            S_SQRT: begin
                alu_req.a  = NW'(sq_rp);
                alu_req.b  = NW'({root_reg, 2'b01});
                alu_req.op = rwsd_pkg::ALU_SUB;
                if (alu_rsp.ge) begin
                    srem_next = rwsd_pkg::SQ_RW'(alu_rsp.res);
                    root_next = {root_reg[SB-2:0], 1'b1};
                end else begin
                    srem_next = sq_rp;
                    root_next = {root_reg[SB-2:0], 1'b0};
                end
                quo_next = quo_reg << 2;
                cnt_next = cnt_reg - rwsd_pkg::CNT_W'(1);
                if (cnt_reg == rwsd_pkg::CNT_W'(1)) begin
                    err_next   = 1'b0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_std_next   = root_reg;
                    m_err_next   = err_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (series_clear) begin
            slot_next = '0;
            fill_next = '0;
            sum_next  = '0;
            sq_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            win_len_reg <= rwsd_pkg::CFG_LEN_W'(rwsd_pkg::RESET_WINDOW);
            mode_reg    <= 1'b1;
            slot_reg    <= '0;
            fill_reg    <= '0;
            sum_reg     <= '0;
            sq_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            win_len_reg <= win_len_next;
            mode_reg    <= mode_next;
            slot_reg    <= slot_next;
            fill_reg    <= fill_next;
            sum_reg     <= sum_next;
            sq_reg      <= sq_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg        <= x_next;
        n_reg        <= n_next;
        have_old_reg <= have_old_next;
        acc_reg      <= acc_next;
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        cnt_reg      <= cnt_next;
        den_reg      <= den_next;
        drem_reg     <= drem_next;
        quo_reg      <= quo_next;
        srem_reg     <= srem_next;
        root_reg     <= root_next;
        err_reg      <= err_next;
        m_std_reg    <= m_std_next;
        m_err_reg    <= m_err_next;
    end

    // ---------------- ports ----------------
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = rwsd_pkg::M_TDATA_W'(m_std_reg);
    assign m_tuser  = m_err_reg;

endmodule
`default_nettype wire
